FILE: rtl/core/srs_pkg.sv
// shared types and constants of the substring replace stream block
// command beat passed from the window front to the output sequencer
// depends on nothing
`default_nettype none

package srs_pkg;

	localparam int BYTE_W      = 8;
	localparam int MAX_PATTERN = 8;
	localparam int MAX_REPLACE = 8;
	localparam int CFG_W       = 64;
	localparam int LEN_W       = 4;
	// a command carries either a window image or the replacement
	localparam int CMD_BYTES   = (MAX_PATTERN > MAX_REPLACE) ? MAX_PATTERN : MAX_REPLACE;
	localparam int IDX_W       = $clog2(CMD_BYTES);
	localparam int CNT_W       = $clog2(CMD_BYTES + 1);
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		REG_PATTERN_BYTES      = 2'd0,
		REG_PATTERN_LENGTH     = 2'd1,
		REG_REPLACEMENT_BYTES  = 2'd2,
		REG_REPLACEMENT_LENGTH = 2'd3
	} reg_index_t;

	// count zero with last set means one empty end-of-text result
	typedef struct packed {
		logic [CMD_BYTES*BYTE_W-1:0] data;
		logic [CNT_W-1:0]            count;
		logic                        last;
	} cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/srs_front.sv
// front of the replace block: configuration registers, sliding window,
// pattern compare, and one command beat per input byte that emits anything
// depends on srs_pkg
`default_nettype none

module srs_front (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire [1:0]                   cfg_index,
	input  wire [srs_pkg::CFG_W-1:0]    cfg_data,
	input  wire                         accept,
	input  wire [srs_pkg::BYTE_W-1:0]   data_byte,
	input  wire                         end_of_text,
	output logic                        cmd_valid,
	output srs_pkg::cmd_t               cmd
);
	import srs_pkg::*;

	logic [MAX_PATTERN*BYTE_W-1:0] pat_bytes_q;
	logic [LEN_W-1:0]              pat_len_q;
	logic [MAX_REPLACE*BYTE_W-1:0] rep_bytes_q;
	logic [LEN_W-1:0]              rep_len_q;
	logic [BYTE_W-1:0]             win_q [MAX_PATTERN];
	logic [LEN_W-1:0]              fill_q;

	logic [LEN_W-1:0]  plen, rlen, fill_eff, fill_new, fill_nxt;
	logic [BYTE_W-1:0] win_new [MAX_PATTERN];
	logic [BYTE_W-1:0] win_nxt [MAX_PATTERN];
	logic              full_now, match;

	always_comb begin
		plen = (pat_len_q > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pat_len_q;
		rlen = (rep_len_q > LEN_W'(MAX_REPLACE)) ? LEN_W'(MAX_REPLACE) : rep_len_q;
		fill_eff = (fill_q >= plen) ? '0 : fill_q;
		fill_new = fill_eff + LEN_W'(1);
		full_now = (fill_new == plen);
		match = 1'b1;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			win_new[i] = (LEN_W'(i) == fill_eff) ? data_byte : win_q[i];
			if (LEN_W'(i) < plen && win_new[i] != pat_bytes_q[i*BYTE_W +: BYTE_W])
				match = 1'b0;
		end

		cmd.data  = '0;
		cmd.count = '0;
		cmd.last  = end_of_text;
		fill_nxt  = fill_new;
		for (int i = 0; i < MAX_PATTERN; i++)
			win_nxt[i] = win_new[i];

		if (plen == '0) begin
			// pass through
			cmd.data[BYTE_W-1:0] = data_byte;
			cmd.count = CNT_W'(1);
			fill_nxt  = '0;
		end else if (full_now && match) begin
			cmd.data[MAX_REPLACE*BYTE_W-1:0] = rep_bytes_q;
			cmd.count = CNT_W'(rlen);
			fill_nxt  = '0;
		end else begin
			// window image: a miss sends its oldest byte, the end mark flushes all
			for (int i = 0; i < MAX_PATTERN; i++)
				cmd.data[i*BYTE_W +: BYTE_W] = win_new[i];
			if (full_now) begin
				cmd.count = end_of_text ? CNT_W'(plen) : CNT_W'(1);
				fill_nxt  = plen - LEN_W'(1);
				for (int i = 0; i < MAX_PATTERN - 1; i++)
					win_nxt[i] = win_new[i+1];
			end else begin
				cmd.count = end_of_text ? CNT_W'(fill_new) : '0;
			end
		end
		if (end_of_text)
			fill_nxt = '0;
		cmd_valid = accept && (end_of_text || cmd.count != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_len_q <= '0;
			rep_len_q <= '0;
			fill_q    <= '0;
		end else begin
			if (accept)
				fill_q <= fill_nxt;
			if (cfg_we) begin
				case (reg_index_t'(cfg_index))
					REG_PATTERN_LENGTH: begin
						pat_len_q <= cfg_data[LEN_W-1:0];
						fill_q    <= '0;
					end
					REG_REPLACEMENT_LENGTH: rep_len_q <= cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// byte registers reset to zero like the configuration space
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_bytes_q <= '0;
			rep_bytes_q <= '0;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_PATTERN_BYTES:     pat_bytes_q <= cfg_data[MAX_PATTERN*BYTE_W-1:0];
				REG_REPLACEMENT_BYTES: rep_bytes_q <= cfg_data[MAX_REPLACE*BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	// window contents are only read below the fill mark
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < MAX_PATTERN; i++)
				win_q[i] <= win_nxt[i];
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0) || (fill_q < plen))
		else $error("window fill reached pattern length");

endmodule

`default_nettype wire

FILE: rtl/core/srs_cmd_queue.sv
// two-entry command queue between the window front and the sequencer
// depends on srs_pkg
`default_nettype none

module srs_cmd_queue (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            wr_en,
	input  srs_pkg::cmd_t  wr_cmd,
	input  wire            rd_en,
	output srs_pkg::cmd_t  rd_cmd,
	output logic           full,
	output logic           q_empty
);
	import srs_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full    = (cnt_q == QCNT_W'(QDEPTH));
	assign q_empty = (cnt_q == '0);
	assign rd_cmd  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			if (rd_en)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_cmd;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !(wr_en && !rd_en))
		else $error("command queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_empty |-> !rd_en)
		else $error("command queue read while empty");

endmodule

`default_nettype wire

FILE: rtl/core/srs_back.sv
// output sequencer: walks the bytes of the head command, one result beat
// per cycle while the output register is free or popped, into a single output register
// depends on srs_pkg
`default_nettype none

module srs_back (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        head_valid,
	input  srs_pkg::cmd_t              head,
	output logic                       head_done,
	input  wire                        pop,
	output logic                       empty,
	output logic [srs_pkg::BYTE_W-1:0] out_byte,
	output logic                       no_data,
	output logic                       last_of_text
);
	import srs_pkg::*;

	logic [IDX_W-1:0]  idx_q;
	logic              out_valid_q;
	logic              load, final_beat;

	assign load       = head_valid && (!out_valid_q || pop);
	assign final_beat = (head.count == '0) ||
	                    ({1'b0, idx_q} == head.count - CNT_W'(1));
	assign head_done  = load && final_beat;
	assign empty      = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
			if (load)
				idx_q <= final_beat ? '0 : idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte     <= (head.count == '0) ? '0 : head.data[idx_q*BYTE_W +: BYTE_W];
			no_data      <= (head.count == '0);
			last_of_text <= final_beat && head.last;
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(head_valid && head.count != '0) |-> ({1'b0, idx_q} < head.count))
		else $error("sequencer index past command length");
	a_idx_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> (idx_q == '0))
		else $error("sequencer index left mid-command");

endmodule

`default_nettype wire

FILE: rtl/core/substring_replace_stream.sv
// top level of the streaming find-and-replace-all block
// front window/compare, command queue and output sequencer
// depends on srs_pkg, srs_front, srs_cmd_queue, srs_back
//
//  channel   handshake          payload
//  -------   ---------          -------
//  input     push / full        data_byte, end_of_text
//  result    empty / pop        out_byte, no_data, last_of_text
//  config    cfg_we             cfg_index, cfg_data (no read-back)
//
// an input beat is taken every cycle while the two-entry command queue has room
// a byte that emits k results (k up to 8) holds the output sequencer until all k
// of its result beats have been loaded into the output register
// a byte's first result passes the command queue, then the output register
// reset clears fill count, queue and output valid; window bytes need no clearing
// full rises only when the queue holds two commands; pop stalls the back side
`default_nettype none

module substring_replace_stream (
	input  wire                         clk,
	input  wire                         arst_n,
	// configuration
	input  wire                         cfg_we,
	input  wire [1:0]                   cfg_index,
	input  wire [srs_pkg::CFG_W-1:0]    cfg_data,
	// input beats
	input  wire                         push,
	output logic                        full,
	input  wire [srs_pkg::BYTE_W-1:0]   data_byte,
	input  wire                         end_of_text,
	// result beats
	output logic                        empty,
	input  wire                         pop,
	output logic [srs_pkg::BYTE_W-1:0]  out_byte,
	output logic                        no_data,
	output logic                        last_of_text
);
	import srs_pkg::*;

	logic accept;
	logic cmd_valid;
	cmd_t cmd;
	cmd_t head;
	logic q_empty;
	logic head_done;

	// a pushed beat is taken whenever the queue is not full
	assign accept = push && !full;

	// window, compare and classification of each input beat
	srs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.accept      (accept),
		.data_byte   (data_byte),
		.end_of_text (end_of_text),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd)
	);

	// decouples the front from result back-pressure
	srs_cmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_valid),
		.wr_cmd  (cmd),
		.rd_en   (head_done),
		.rd_cmd  (head),
		.full    (full),
		.q_empty (q_empty)
	);

	// expands each command into result beats
	srs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (!q_empty),
		.head         (head),
		.head_done    (head_done),
		.pop          (pop),
		.empty        (empty),
		.out_byte     (out_byte),
		.no_data      (no_data),
		.last_of_text (last_of_text)
	);

	// a stalled full queue must never see the front enqueue
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !cmd_valid)
		else $error("command produced while queue full");

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// self-checking bench for substring_replace_stream: directed table, then random texts
// under several pattern/replacement settings, checked beat by beat against a predictor
// depends on srs_pkg and the substring_replace_stream rtl

module tb_top;

	import srs_pkg::*;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int RANDOM_ITEMS  = 150;
	// first result passes the command queue and the output register, leave a margin
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 100;
	// n_exp value in a table row meaning: take the expectation from the predictor
	localparam int BY_MODEL      = -1;

	// one result beat of the rewritten text
	typedef struct packed {
		logic [BYTE_W-1:0] ch;
		logic              nd;
		logic              last;
	} text_beat_t;

	typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;

	// receiver stall styles, one picked at random from time to time
	typedef enum logic [1:0] {RX_FLOW, RX_COIN, RX_CADENCE, RX_TRICKLE} rx_style_t;

	typedef struct {
		row_kind_t         kind;
		reg_index_t        sel;       // register for a config row
		logic [CFG_W-1:0]  value;
		logic [BYTE_W-1:0] b;         // byte for a data row
		logic              eot;
		int                n_exp;     // typed result count, or BY_MODEL
		logic [CFG_W-1:0]  exp_bytes; // typed result bytes, first in bits 7..0
		logic              exp_nd;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [1:0]          cfg_index;
	logic [CFG_W-1:0]    cfg_data;
	logic                push;
	logic                full;
	logic [BYTE_W-1:0]   data_byte;
	logic                end_of_text;
	logic                empty;
	logic                pop;
	logic [BYTE_W-1:0]   out_byte;
	logic                no_data;
	logic                last_of_text;

	// predictor copy of the registers and the sliding window
	logic [CFG_W-1:0]    pat_bytes;
	logic [LEN_W-1:0]    pat_len;
	logic [CFG_W-1:0]    rep_bytes;
	logic [LEN_W-1:0]    rep_len;
	logic [BYTE_W-1:0]   win [0:MAX_PATTERN-1];
	int                  win_fill;

	// results of the latest byte, then the store of results still owed by the dut
	text_beat_t          step_beats [0:MAX_PATTERN];
	int                  step_n;
	text_beat_t          owed_beats [$];

	int                  fail_count;
	int                  checked_count;
	int                  fed_count;
	int                  text_count;
	int                  setting_count;
	int                  random_items;
	int                  held_cycles;
	int                  burst_left;
	bit                  quiet;
	bit                  hold_req;
	int                  cycle_count;

	// directed part: pass through after reset, match/miss/tail flush, deletion with the
	// empty end beat, clamped lengths with a full eight-byte replacement, and the window
	// being dropped when the pattern length is rewritten in the middle of a text
	stim_row_t directed_rows [0:35] = '{
		// reset state: pattern length zero passes bytes through
		'{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h00, 1'b0, 1, 64'h00, 1'b0},
		'{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'hff, 1'b1, 1, 64'hff, 1'b0},
		// "ab" -> "XYZ"
		'{ROW_CFG, REG_PATTERN_BYTES, 64'h6261, 8'h00, 1'b0, 0, 64'h0, 1'b0},
		'{ROW_CFG, REG_PATTERN_LENGTH, 64'd2, 8'h00, 1'b0, 0, 64'h0, 1'b0},
		'{ROW_CFG, REG_REPLACEMENT_BYTES, 64'h5a5958, 8'h00, 1'b0, 0, 64'h0, 1'b0},
		'{ROW_CFG, REG_REPLACEMENT_LENGTH, 64'd3, 8'h00, 1'b0, 0, 64'h0, 1'b0},
		'{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h61, 1'b0, 0, 64'h0, 1'b0},
		'{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h62, 1'b0, 3, 64'h5a5958, 1'b0},
		'{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h61, 1'b0, 0, 64'h0, 1'b0},
		// "aa" misses, oldest byte goes out
		'{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h61, 1'b0, 1, 64'h61, 1'b0},
		'{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h62, 1'b0, 3, 64'h5a5958, 1'b0},
		// tail byte flushed at the end mark
		'{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h63, 1'b1, 1, 64'h63, 1'b0},
		// empty replacement deletes, text ends with nothing left -> empty end beat
		'{ROW_CFG, REG_REPLACEMENT_LENGTH, 64'd0, 8'h00, 1'b0, 0, 64'h0, 1'b0},
		'{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h61, 1'b0, 0, 64'h0, 1'b0},
		'{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h62, 1'b1, 1, 64'h0, 1'b1},
		// lengths above maximum are clamped to eight
		'{ROW_CFG, REG_PATTERN_BYTES, 64'hffff_ffff_ffff_ffff, 8'h00, 1'b0, 0, 64'h0, 1'b0},
		'{ROW_CFG, REG_PATTERN_LENGTH, 64'd15, 8'h00, 1'b0, 0, 64'h0, 1'b0},
		'{ROW_CFG, REG_REPLACEMENT_BYTES, 64'h8000_ff7f_01fe_aa55, 8'h00, 1'b0, 0,
			64'h0, 1'b0},
		'{ROW_CFG, REG_REPLACEMENT_LENGTH, 64'd15, 8'h00, 1'b0, 0, 64'h0, 1'b0},
		'{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'hff, 1'b0, 0, 64'h0, 1'b0},
		'{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'hff, 1'b0, 0, 64'h0, 1'b0},
		'{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'hff, 1'b0, 0, 64'h0, 1'b0},
		'{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'hff, 1'b0, 0, 64'h0, 1'b0},
		'{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'hff, 1'b0, 0, 64'h0, 1'b0},
		'{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'hff, 1'b0, 0, 64'h0, 1'b0},
		'{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'hff, 1'b0, 0, 64'h0, 1'b0},
		'{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'hff, 1'b1, 8, 64'h8000_ff7f_01fe_aa55,
			1'b0},
		// rewriting the pattern length drops the two held zeros, so no match follows
		'{ROW_CFG, REG_PATTERN_BYTES, 64'h0, 8'h00, 1'b0, 0, 64'h0, 1'b0},
		'{ROW_CFG, REG_PATTERN_LENGTH, 64'd3, 8'h00, 1'b0, 0, 64'h0, 1'b0},
		'{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h00, 1'b0, 0, 64'h0, 1'b0},
		'{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h00, 1'b0, 0, 64'h0, 1'b0},
		'{ROW_CFG, REG_PATTERN_LENGTH, 64'd3, 8'h00, 1'b0, 0, 64'h0, 1'b0},
		'{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h00, 1'b1, 1, 64'h00, 1'b0},
		'{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h00, 1'b0, BY_MODEL, 64'h0, 1'b0},
		'{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h01, 1'b0, BY_MODEL, 64'h0, 1'b0},
		'{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h00, 1'b1, BY_MODEL, 64'h0, 1'b0}
	};

	substring_replace_stream dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.push         (push),
		.full         (full),
		.data_byte    (data_byte),
		.end_of_text  (end_of_text),
		.empty        (empty),
		.pop          (pop),
		.out_byte     (out_byte),
		.no_data      (no_data),
		.last_of_text (last_of_text)
	);

	always #6 clk = ~clk;

	function automatic int clamp_len(input logic [LEN_W-1:0] v, input int max_len);
		clamp_len = (int'(v) > max_len) ? max_len : int'(v);
	endfunction

	// length register value: mostly in range, with zero, the maximum and above it
	function automatic logic [CFG_W-1:0] pick_len();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: pick_len = 64'd0;
			1: pick_len = 64'd8;
			2: pick_len = 64'd15;
			3: pick_len = 64'($urandom_range(9, 15));
			default: pick_len = 64'($urandom_range(1, 7));
		endcase
	endfunction

	// window step for one text byte, results land in step_beats/step_n
	task automatic rewrite_byte(input logic [BYTE_W-1:0] b, input logic eot);
		int plen;
		int rlen;
		bit hit;
		plen = clamp_len(pat_len, MAX_PATTERN);
		rlen = clamp_len(rep_len, MAX_REPLACE);
		step_n = 0;
		if (plen == 0) begin
			// pass through, window stays empty
			win_fill = 0;
			step_beats[0] = {b, 1'b0, eot};
			step_n = 1;
		end else begin
			if (win_fill >= plen)
				win_fill = 0;
			win[win_fill] = b;
			win_fill++;
			if (win_fill == plen) begin
				hit = 1'b1;
				for (int i = 0; i < plen; i++)
					if (win[i] != pat_bytes[8*i +: 8])
						hit = 1'b0;
				if (hit) begin
					// whole replacement, window starts over: no overlapping matches
					for (int i = 0; i < rlen; i++)
						step_beats[step_n++] = {rep_bytes[8*i +: 8], 1'b0, 1'b0};
					win_fill = 0;
				end else begin
					// miss: oldest byte leaves, the rest slide down
					step_beats[step_n++] = {win[0], 1'b0, 1'b0};
					for (int i = 1; i < plen; i++)
						win[i-1] = win[i];
					win_fill = plen - 1;
				end
			end
			if (eot) begin
				for (int i = 0; i < win_fill; i++)
					step_beats[step_n++] = {win[i], 1'b0, 1'b0};
				win_fill = 0;
				if (step_n == 0)
					step_beats[step_n++] = {8'h00, 1'b1, 1'b1};
				else
					step_beats[step_n-1].last = 1'b1;
			end
		end
	endtask

	// drop push, wait for every owed beat, then give in-flight bytes time to land
	task automatic wait_idle();
		push <= 1'b0;
		while (owed_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t sel, input logic [CFG_W-1:0] v);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (sel)
			REG_PATTERN_BYTES:      pat_bytes = v;
			REG_PATTERN_LENGTH: begin
				// a new pattern length empties the window
				pat_len  = v[LEN_W-1:0];
				win_fill = 0;
			end
			REG_REPLACEMENT_BYTES:  rep_bytes = v;
			REG_REPLACEMENT_LENGTH: rep_len = v[LEN_W-1:0];
			default: ;
		endcase
	endtask

	// offer one input beat in bursts with gaps, then book what it should produce
	task automatic feed_byte(input logic [BYTE_W-1:0] b, input logic eot, input int n_typed,
			input logic [CFG_W-1:0] typed_bytes, input logic typed_nd);
		if (!quiet && burst_left == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0)
			burst_left--;
		push        <= 1'b1;
		data_byte   <= b;
		end_of_text <= eot;
		@(posedge clk);
		// beat taken at the first edge with full low
		while (full) begin
			held_cycles++;
			@(posedge clk);
		end
		rewrite_byte(b, eot);
		if (n_typed == BY_MODEL) begin
			for (int k = 0; k < step_n; k++)
				owed_beats.push_back(step_beats[k]);
		end else begin
			for (int k = 0; k < n_typed; k++)
				owed_beats.push_back({typed_bytes[8*k +: 8], typed_nd,
					eot && (k == n_typed - 1)});
		end
		fed_count++;
		if (eot)
			text_count++;
	endtask

	// one text: mostly whole or partial copies of the pattern and pattern bytes, so that
	// matches, near misses and overlaps are frequent; some texts are plain noise
	task automatic random_text();
		logic [BYTE_W-1:0] text [$];
		int plen;
		int len;
		int r;
		int cut;
		int idx;
		bit noisy;
		plen  = clamp_len(pat_len, MAX_PATTERN);
		len   = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 24);
		noisy = ($urandom_range(0, 9) == 0);
		while (text.size() < len) begin
			r = (noisy || plen == 0) ? 9 : $urandom_range(0, 9);
			if (r < 4) begin
				for (int i = 0; i < plen; i++)
					text.push_back(pat_bytes[8*i +: 8]);
			end else if (r < 6) begin
				cut = $urandom_range(1, plen);
				for (int i = 0; i < cut; i++)
					text.push_back(pat_bytes[8*i +: 8]);
			end else if (r < 8) begin
				idx = $urandom_range(0, plen - 1);
				text.push_back(pat_bytes[8*idx +: 8]);
			end else begin
				text.push_back(8'($urandom_range(0, 255)));
			end
		end
		foreach (text[i])
			feed_byte(text[i], i == text.size() - 1, BY_MODEL, 64'h0, 1'b0);
		random_items += text.size();
	endtask

	// result side: check every accepted beat, stall on a pattern of its own
	initial begin
		text_beat_t want;
		rx_style_t style;
		int rx_cycles;
		int hold_left;
		bit hold_done;
		bit go;
		pop       <= 1'b0;
		style     = RX_FLOW;
		rx_cycles = 0;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				if (owed_beats.size() == 0) begin
					$error("result beat with nothing owed: out_byte %02h no_data %0b last_of_text %0b",
						out_byte, no_data, last_of_text);
					fail_count++;
				end else begin
					want = owed_beats.pop_front();
					checked_count++;
					if (out_byte !== want.ch) begin
						$error("out_byte: expected %02h, got %02h", want.ch, out_byte);
						fail_count++;
					end
					if (no_data !== want.nd) begin
						$error("no_data: expected %0b, got %0b", want.nd, no_data);
						fail_count++;
					end
					if (last_of_text !== want.last) begin
						$error("last_of_text: expected %0b, got %0b", want.last, last_of_text);
						fail_count++;
					end
				end
			end
			rx_cycles++;
			if (rx_cycles % 48 == 0)
				style = rx_style_t'($urandom_range(0, 3));
			case (style)
				RX_FLOW:    go = 1'b1;
				RX_COIN:    go = $urandom_range(0, 1);
				RX_CADENCE: go = (rx_cycles % 3) != 0;
				default:    go = ($urandom_range(0, 3) == 0);
			endcase
			// one long hold-off so the command queue fills and full pushes back
			if (hold_req && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				go = 1'b0;
			end
			if (!arst_n)
				go = 1'b0;
			pop <= go;
		end
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		push        <= 1'b0;
		data_byte   <= '0;
		end_of_text <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= REG_PATTERN_BYTES;
		cfg_data    <= '0;
		arst_n      <= 1'b0;
		// predictor state after reset
		pat_bytes     = '0;
		pat_len       = '0;
		rep_bytes     = '0;
		rep_len       = '0;
		win_fill      = 0;
		fail_count    = 0;
		checked_count = 0;
		fed_count     = 0;
		text_count    = 0;
		setting_count = 0;
		random_items  = 0;
		held_cycles   = 0;
		burst_left    = 0;
		quiet         = 1'b0;
		hold_req      = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG)
				write_reg(directed_rows[i].sel, directed_rows[i].value);
			else
				feed_byte(directed_rows[i].b, directed_rows[i].eot, directed_rows[i].n_exp,
					directed_rows[i].exp_bytes, directed_rows[i].exp_nd);
		end

		// random settings, a few texts under each
		while (random_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 1))
				write_reg(REG_PATTERN_BYTES, {$urandom, $urandom});
			else
				write_reg(REG_PATTERN_BYTES, {8'h61 + 8'($urandom_range(0, 1)),
					8'h61 + 8'($urandom_range(0, 1)), 8'h61 + 8'($urandom_range(0, 1)),
					8'h61 + 8'($urandom_range(0, 1)), 8'h61 + 8'($urandom_range(0, 1)),
					8'h61 + 8'($urandom_range(0, 1)), 8'h61 + 8'($urandom_range(0, 1)),
					8'h61 + 8'($urandom_range(0, 1))});
			write_reg(REG_PATTERN_LENGTH, pick_len());
			write_reg(REG_REPLACEMENT_BYTES, {$urandom, $urandom});
			write_reg(REG_REPLACEMENT_LENGTH, pick_len());
			setting_count++;
			// some settings run the sender back to back
			quiet = ($urandom_range(0, 2) == 0);
			if (setting_count == 2)
				hold_req = 1'b1;
			repeat ($urandom_range(2, 4)) random_text();
		end

		wait_idle();
		$display("covered %0d input beats in %0d texts over %0d random register settings",
			fed_count, text_count, setting_count);
		$display("checked %0d result beats, input held back by full on %0d cycles",
			checked_count, held_cycles);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
